FILE: design/sed_pkg.sv
// Shared types and character constants for the string escape decoder.
package sed_pkg;

    // One held source character, classified on entry.
    typedef struct packed {
        logic [7:0] ch;
        logic       hexv;
        logic [3:0] nib;
    } pend_t;

    // One queued source word between the front and back parts.
    typedef struct packed {
        pend_t pend;
        logic  last;
    } qword_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_UU     = 8'h55;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    localparam logic [7:0] BY_LF  = 8'h0A;
    localparam logic [7:0] BY_TAB = 8'h09;
    localparam logic [7:0] BY_CR  = 8'h0D;
    localparam logic [7:0] BY_BEL = 8'h07;
    localparam logic [7:0] BY_BS  = 8'h08;
    localparam logic [7:0] BY_FF  = 8'h0C;
    localparam logic [7:0] BY_VT  = 8'h0B;

    localparam logic [31:0] CP_MAX    = 32'h0010FFFF;
    localparam logic [31:0] SUR_FIRST = 32'h0000D800;
    localparam logic [31:0] SUR_LAST  = 32'h0000DFFF;
    localparam logic [15:0] HI_FIRST  = 16'hD800;
    localparam logic [15:0] HI_LAST   = 16'hDBFF;
    localparam logic [15:0] LO_FIRST  = 16'hDC00;
    localparam logic [15:0] LO_LAST   = 16'hDFFF;
    localparam logic [20:0] CP_PLANE1 = 21'h10000;

endpackage

FILE: design/sed_if.sv
// Channel interfaces for source characters and decoded bytes.
interface sed_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       text_last;

    modport source (output valid, output in_char, output text_last, input ready);
    modport sink (input valid, input in_char, input text_last, output ready);
endinterface

interface sed_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output run_last, output text_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input text_end,
                  output ready);
endinterface

FILE: design/sed_front.sv
// Front part: accept source words, classify them, queue them for the back part.
module sed_front
(
    input  logic                clk,
    input  logic                rst_n,
    sed_text_if.sink            text,
    output logic                q_valid,
    output sed_pkg::qword_t     q_word,
    input  logic                q_pop
);

    sed_pkg::qword_t q_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    sed_pkg::qword_t in_word;
    logic            push;
    logic            pop;

    always_comb
    begin
        in_word.pend.ch   = text.in_char;
        in_word.pend.hexv = (text.in_char inside {[sed_pkg::CH_0 : sed_pkg::CH_9],
                                                 [sed_pkg::CH_LA : sed_pkg::CH_LF],
                                                 [sed_pkg::CH_UA : sed_pkg::CH_UF]});
        in_word.pend.nib  = (text.in_char <= sed_pkg::CH_9) ? text.in_char[3:0]
                                                            : text.in_char[3:0] + 4'd9;
        in_word.last      = text.text_last;
    end

    assign text.ready = (cnt_reg != 2'd2);
    assign push       = text.valid && text.ready;
    assign q_valid    = (cnt_reg != 2'd0);
    assign pop        = q_pop && q_valid;
    assign q_word     = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: design/sed_back.sv
// Back part: pending buffer, escape decision, byte emission and output register.
module sed_back
#(
    parameter int PENDING_DEPTH = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sed_pkg::qword_t     q_word,
    output logic                q_pop,
    sed_byte_if.source          decoded
);

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = $clog2(PENDING_DEPTH);
    localparam int WIN   = 16;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic            need;
        logic [3:0]      used;
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } dec_t;

    state_t             state_reg, state_next;
    sed_pkg::pend_t     buf_reg [PENDING_DEPTH];
    sed_pkg::pend_t     buf_next [PENDING_DEPTH];
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               fin_reg, fin_next;
    dec_t               dec_reg, dec_next;
    logic [1:0]         idx_reg, idx_next;
    logic [7:0]         hold_reg, hold_next;
    logic               hold_vld_reg, hold_vld_next;
    logic               out_vld_reg, out_vld_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_run_reg, out_run_next;
    logic               out_end_reg, out_end_next;

    logic [WIN-1:0]       av;
    logic [WIN-1:0]       hx;
    logic [WIN-1:0][7:0]  chv;
    logic [WIN-1:0][3:0]  nb;
    dec_t                 dec;
    logic                 out_free;
    logic                 emit_ok;
    logic                 produce;
    logic [7:0]           prod_byte;
    logic                 step_end;
    logic                 do_shift;
    logic [3:0]           shamt;
    logic                 do_append;
    logic                 clear_first;
    logic [CNT_W-1:0]     base;

    function automatic logic [1:0] hex_scan(input logic [WIN-1:0] a, input logic [WIN-1:0] h,
                                            input int start, input int k, input logic fin);
        logic done;
        logic ok;
        logic sh;
        done = 1'b0;
        ok   = 1'b1;
        sh   = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < k && !done)
            begin
                if (!a[4'(start + i)])
                begin
                    done = 1'b1;
                    ok   = 1'b0;
                    sh   = !fin;
                end
                else if (!h[4'(start + i)])
                begin
                    done = 1'b1;
                    ok   = 1'b0;
                end
            end
        end
        return {sh, ok};
    endfunction

    function automatic dec_t put_utf8(input dec_t d, input logic [20:0] cp);
        dec_t r;
        r = d;
        if (cp < 21'h80)
        begin
            r.n    = 3'd1;
            r.b[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            r.n    = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            r.n    = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.n    = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // Window over the head of the buffer.
    always_comb
    begin
        for (int p = 0; p < WIN; p++)
        begin
            av[p]  = (p < int'(cnt_reg));
            hx[p]  = 1'b0;
            chv[p] = 8'h00;
            nb[p]  = 4'h0;
            if (p < PENDING_DEPTH)
            begin
                hx[p]  = buf_reg[IDX_W'(p)].hexv;
                chv[p] = buf_reg[IDX_W'(p)].ch;
                nb[p]  = buf_reg[IDX_W'(p)].nib;
            end
        end
    end

    // Escape decision for a backslash at the head of the buffer.
    always_comb
    begin
        logic [1:0]  s1;
        logic [1:0]  s2;
        logic [15:0] u4;
        logic [15:0] lo;
        logic [31:0] u8;
        logic [20:0] pcp;
        s1   = 2'b00;
        s2   = 2'b00;
        u4   = {nb[2], nb[3], nb[4], nb[5]};
        lo   = {nb[8], nb[9], nb[10], nb[11]};
        u8   = {nb[2], nb[3], nb[4], nb[5], nb[6], nb[7], nb[8], nb[9]};
        pcp  = sed_pkg::CP_PLANE1 + {1'b0, u4[9:0], lo[9:0]};
        dec.need = 1'b0;
        dec.used = 4'd2;
        dec.n    = 3'd2;
        dec.b    = '0;
        dec.b[0] = sed_pkg::CH_BSLASH;
        dec.b[1] = chv[1];
        if (!av[1])
        begin
            if (!fin_reg)
            begin
                dec.need = 1'b1;
            end
            else
            begin
                dec.used = 4'd1;
                dec.n    = 3'd1;
            end
        end
        else
        begin
            case (chv[1])
                sed_pkg::CH_N:      begin dec.n = 3'd1; dec.b[0] = sed_pkg::BY_LF;     end
                sed_pkg::CH_T:      begin dec.n = 3'd1; dec.b[0] = sed_pkg::BY_TAB;    end
                sed_pkg::CH_R:      begin dec.n = 3'd1; dec.b[0] = sed_pkg::BY_CR;     end
                sed_pkg::CH_A:      begin dec.n = 3'd1; dec.b[0] = sed_pkg::BY_BEL;    end
                sed_pkg::CH_B:      begin dec.n = 3'd1; dec.b[0] = sed_pkg::BY_BS;     end
                sed_pkg::CH_F:      begin dec.n = 3'd1; dec.b[0] = sed_pkg::BY_FF;     end
                sed_pkg::CH_V:      begin dec.n = 3'd1; dec.b[0] = sed_pkg::BY_VT;     end
                sed_pkg::CH_BSLASH: begin dec.n = 3'd1; dec.b[0] = sed_pkg::CH_BSLASH; end
                sed_pkg::CH_SQUOTE: begin dec.n = 3'd1; dec.b[0] = sed_pkg::CH_SQUOTE; end
                sed_pkg::CH_DQUOTE: begin dec.n = 3'd1; dec.b[0] = sed_pkg::CH_DQUOTE; end
                sed_pkg::CH_X:
                begin
                    if (!av[2] && !fin_reg)
                    begin
                        dec.need = 1'b1;
                    end
                    else if (av[2] && hx[2])
                    begin
                        if (!av[3] && !fin_reg)
                        begin
                            dec.need = 1'b1;
                        end
                        else if (av[3] && hx[3])
                        begin
                            dec.n    = 3'd1;
                            dec.used = 4'd4;
                            dec.b[0] = {nb[2], nb[3]};
                        end
                        else
                        begin
                            dec.n    = 3'd1;
                            dec.used = 4'd3;
                            dec.b[0] = {4'h0, nb[2]};
                        end
                    end
                end
                sed_pkg::CH_LU:
                begin
                    s1 = hex_scan(av, hx, 2, 4, fin_reg);
                    if (s1[1])
                    begin
                        dec.need = 1'b1;
                    end
                    else if (s1[0])
                    begin
                        if (u4 >= sed_pkg::HI_FIRST && u4 <= sed_pkg::HI_LAST)
                        begin
                            // High surrogate: look for a following low surrogate.
                            if (!av[6])
                            begin
                                dec.need = !fin_reg;
                            end
                            else if (chv[6] == sed_pkg::CH_BSLASH)
                            begin
                                if (!av[7])
                                begin
                                    dec.need = !fin_reg;
                                end
                                else if (chv[7] == sed_pkg::CH_LU)
                                begin
                                    s2 = hex_scan(av, hx, 8, 4, fin_reg);
                                    if (s2[1])
                                    begin
                                        dec.need = 1'b1;
                                    end
                                    else if (s2[0] && lo >= sed_pkg::LO_FIRST
                                             && lo <= sed_pkg::LO_LAST)
                                    begin
                                        dec      = put_utf8(dec, pcp);
                                        dec.used = 4'd12;
                                    end
                                end
                            end
                        end
                        else if (!(u4 >= sed_pkg::LO_FIRST && u4 <= sed_pkg::LO_LAST))
                        begin
                            dec      = put_utf8(dec, {5'd0, u4});
                            dec.used = 4'd6;
                        end
                    end
                end
                sed_pkg::CH_UU:
                begin
                    s1 = hex_scan(av, hx, 2, 8, fin_reg);
                    if (s1[1])
                    begin
                        dec.need = 1'b1;
                    end
                    else if (s1[0] && u8 <= sed_pkg::CP_MAX
                             && !(u8 >= sed_pkg::SUR_FIRST && u8 <= sed_pkg::SUR_LAST))
                    begin
                        dec      = put_utf8(dec, u8[20:0]);
                        dec.used = 4'd10;
                    end
                end
                default:
                begin
                    if (chv[1] inside {[sed_pkg::CH_0 : sed_pkg::CH_7]})
                    begin
                        dec.n    = 3'd1;
                        dec.used = 4'd2;
                        dec.b[0] = {5'd0, chv[1][2:0]};
                        if (!av[2] && !fin_reg)
                        begin
                            dec.need = 1'b1;
                        end
                        else if (av[2] && chv[2] inside {[sed_pkg::CH_0 : sed_pkg::CH_7]})
                        begin
                            if (!av[3] && !fin_reg)
                            begin
                                dec.need = 1'b1;
                            end
                            else if (av[3]
                                     && chv[3] inside {[sed_pkg::CH_0 : sed_pkg::CH_7]})
                            begin
                                dec.used = 4'd4;
                                dec.b[0] = {chv[1][1:0], chv[2][2:0], chv[3][2:0]};
                            end
                            else
                            begin
                                dec.used = 4'd3;
                                dec.b[0] = {2'b00, chv[1][2:0], chv[2][2:0]};
                            end
                        end
                    end
                end
            endcase
        end
    end

    assign out_free = !out_vld_reg || decoded.ready;
    assign emit_ok  = !hold_vld_reg || out_free;

    // Sequencer over the pending buffer.
    always_comb
    begin
        state_next  = state_reg;
        dec_next    = dec_reg;
        idx_next    = idx_reg;
        fin_next    = fin_reg;
        produce     = 1'b0;
        prod_byte   = chv[0];
        step_end    = 1'b0;
        do_shift    = 1'b0;
        shamt       = 4'd1;
        do_append   = 1'b0;
        clear_first = 1'b0;
        q_pop       = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    do_append  = 1'b1;
                    fin_next   = q_word.last;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0 || (chv[0] == sed_pkg::CH_BSLASH && dec.need))
                begin
                    if (emit_ok)
                    begin
                        step_end    = 1'b1;
                        clear_first = fin_reg;
                        if (q_valid)
                        begin
                            q_pop     = 1'b1;
                            do_append = 1'b1;
                            fin_next  = q_word.last;
                        end
                        else
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                end
                else if (chv[0] != sed_pkg::CH_BSLASH)
                begin
                    if (emit_ok)
                    begin
                        produce  = 1'b1;
                        do_shift = 1'b1;
                    end
                end
                else
                begin
                    dec_next   = dec;
                    idx_next   = 2'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                prod_byte = dec_reg.b[idx_reg];
                if (emit_ok)
                begin
                    produce = 1'b1;
                    if (3'(idx_reg) + 3'd1 == dec_reg.n)
                    begin
                        do_shift   = 1'b1;
                        shamt      = dec_reg.used;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Buffer update: drop consumed characters, or append a new one.
    always_comb
    begin
        int j;
        j        = 0;
        base     = clear_first ? '0 : cnt_reg;
        cnt_next = base;
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        if (do_shift)
        begin
            for (int i = 0; i < PENDING_DEPTH; i++)
            begin
                j = i + int'(shamt);
                if (j < PENDING_DEPTH)
                begin
                    buf_next[i] = buf_reg[IDX_W'(j)];
                end
            end
            cnt_next = cnt_reg - CNT_W'(shamt);
        end
        if (do_append && base < CNT_W'(PENDING_DEPTH))
        begin
            buf_next[base[IDX_W-1:0]] = q_word.pend;
            cnt_next = base + CNT_W'(1);
        end
    end

    // Hold the newest byte until it is known whether more follow in this step.
    always_comb
    begin
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        out_vld_next  = out_vld_reg && !decoded.ready;
        out_byte_next = out_byte_reg;
        out_run_next  = out_run_reg;
        out_end_next  = out_end_reg;
        if ((produce || step_end) && hold_vld_reg)
        begin
            out_vld_next  = 1'b1;
            out_byte_next = hold_reg;
            out_run_next  = step_end;
            out_end_next  = step_end && fin_reg;
        end
        if (produce)
        begin
            hold_next     = prod_byte;
            hold_vld_next = 1'b1;
        end
        else if (step_end)
        begin
            hold_vld_next = 1'b0;
        end
    end

    assign decoded.valid    = out_vld_reg;
    assign decoded.out_byte = out_byte_reg;
    assign decoded.run_last = out_run_reg;
    assign decoded.text_end = out_end_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
        dec_reg      <= dec_next;
        hold_reg     <= hold_next;
        out_byte_reg <= out_byte_next;
        out_run_reg  <= out_run_next;
        out_end_reg  <= out_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            fin_reg      <= 1'b0;
            idx_reg      <= 2'd0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fin_reg      <= fin_next;
            idx_reg      <= idx_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

endmodule

FILE: design/string_escape_decoder.sv
// Top level of the string escape decoder: front queue and back decoder.
//
// Usage: source characters enter on the text channel, one word each, with
// text_last on the final character of a text. Decoded bytes leave on the
// decoded channel; run_last marks the last byte caused by one source word,
// text_end the last byte of the whole text.
// Plain characters pass through; backslash escapes (simple, \x, octal, \u,
// \U and surrogate pairs) wait in the pending buffer until decidable and
// come out as bytes or UTF-8.
// Flow: in the back part a plain character is emitted, then the step is
// closed and the next word loaded. An escape is first decided, then its
// bytes are emitted and the step is closed. The back part emits one byte
// per cycle while the output is not stalled, which sets the pace.
// Each byte passes the hold register and then the output register.
// The front queue holds two words, so input keeps flowing while the back
// part emits. When the receiver stalls, the output register holds its
// word, the back part halts, the queue fills and text.ready drops.
// Reset clears the queue, the pending count and the output valid.
module string_escape_decoder
#(
    parameter int PENDING_DEPTH = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    sed_text_if.sink    text,
    sed_byte_if.source  decoded
);

    logic            q_valid;
    sed_pkg::qword_t q_word;
    logic            q_pop;

    sed_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    sed_back
    #(
        .PENDING_DEPTH (PENDING_DEPTH)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop),
        .decoded (decoded)
    );

endmodule

FILE: design/sed_checker.sv
// Port checker for the string escape decoder, bound to the top level.
module sed_checker
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic run_last,
    input logic text_end
);

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("decoded word dropped while stalled");

    // The last byte of a text also closes its source word.
    a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_last)
        else $error("text_end without run_last");

    // No output during reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("decoded valid during reset");

endmodule

bind string_escape_decoder sed_checker u_sed_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .run_last  (decoded.run_last),
    .text_end  (decoded.text_end)
);

FILE: verif/sed_byte_checker.sv
// Checker for the string escape decoder: predicts decoded bytes and compares them.
`timescale 1ns / 100ps

module sed_byte_checker
(
    input  logic clk,
    input  logic rst_n,
    sed_text_if  text,
    sed_byte_if  decoded,
    output int   failures,
    output int   outstanding
);

    localparam int HOLD_DEPTH = 12;
    localparam int MAX_BYTES  = 12;

    typedef struct {
        logic [7:0] value;
        logic       run_last;
        logic       text_end;
    } byte_exp_t;

    byte_exp_t  expected_bytes[$];
    logic [7:0] held_chars[HOLD_DEPTH];
    int         held_count;

    // window of the escape being decided
    int         esc_start;
    int         esc_len;
    bit         esc_final;
    bit         esc_short;
    logic [7:0] esc_bytes[$];

    function automatic int fetch(int p);
        if (p < esc_len)
            return held_chars[esc_start + p];
        if (!esc_final)
            esc_short = 1;
        return -1;
    endfunction

    function automatic bit is_hex(int c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nib(int c);
        if (c >= "a")
            return 4'(c - "a" + 10);
        if (c >= "A")
            return 4'(c - "A" + 10);
        return 4'(c - "0");
    endfunction

    function automatic bit read_hex(int pos, int digits, output logic [31:0] v);
        int c;
        v = 0;
        for (int i = 0; i < digits; i++)
        begin
            c = fetch(pos + i);
            if (c < 0 || !is_hex(c))
                return 0;
            v = {v[27:0], nib(c)};
        end
        return 1;
    endfunction

    function automatic void add_utf8(logic [31:0] cp);
        if (cp < 32'h80)
            esc_bytes.push_back(cp[7:0]);
        else if (cp < 32'h800)
        begin
            esc_bytes.push_back(8'hC0 | cp[10:6]);
            esc_bytes.push_back(8'h80 | cp[5:0]);
        end
        else if (cp < 32'h10000)
        begin
            esc_bytes.push_back(8'hE0 | cp[15:12]);
            esc_bytes.push_back(8'h80 | cp[11:6]);
            esc_bytes.push_back(8'h80 | cp[5:0]);
        end
        else
        begin
            esc_bytes.push_back(8'hF0 | cp[20:18]);
            esc_bytes.push_back(8'h80 | cp[17:12]);
            esc_bytes.push_back(8'h80 | cp[11:6]);
            esc_bytes.push_back(8'h80 | cp[5:0]);
        end
    endfunction

    function automatic bit cp_valid(logic [31:0] cp);
        return cp <= sed_pkg::CP_MAX
               && !(cp >= sed_pkg::SUR_FIRST && cp <= sed_pkg::SUR_LAST);
    endfunction

    // Failed escape: backslash and letter go out, the rest is scanned again.
    function automatic int reject(int c1);
        esc_bytes = {sed_pkg::CH_BSLASH, c1[7:0]};
        return 2;
    endfunction

    // Decide the escape at esc_start; 0 means more characters are needed.
    function automatic int decide_escape();
        int          c1;
        int          c;
        int          cnt;
        logic [31:0] cp;
        logic [31:0] lo;
        logic [31:0] v;
        bit          ok;
        bit          pair;
        esc_bytes = {};
        esc_short = 0;
        c1 = fetch(1);
        if (esc_short)
            return 0;
        if (c1 < 0)
        begin
            esc_bytes.push_back(sed_pkg::CH_BSLASH);
            return 1;
        end
        case (c1)
            sed_pkg::CH_N:      esc_bytes.push_back(sed_pkg::BY_LF);
            sed_pkg::CH_T:      esc_bytes.push_back(sed_pkg::BY_TAB);
            sed_pkg::CH_R:      esc_bytes.push_back(sed_pkg::BY_CR);
            sed_pkg::CH_A:      esc_bytes.push_back(sed_pkg::BY_BEL);
            sed_pkg::CH_B:      esc_bytes.push_back(sed_pkg::BY_BS);
            sed_pkg::CH_F:      esc_bytes.push_back(sed_pkg::BY_FF);
            sed_pkg::CH_V:      esc_bytes.push_back(sed_pkg::BY_VT);
            sed_pkg::CH_BSLASH: esc_bytes.push_back(sed_pkg::CH_BSLASH);
            sed_pkg::CH_SQUOTE: esc_bytes.push_back(sed_pkg::CH_SQUOTE);
            sed_pkg::CH_DQUOTE: esc_bytes.push_back(sed_pkg::CH_DQUOTE);
            default: ;
        endcase
        if (esc_bytes.size() != 0)
            return 2;
        if (c1 == sed_pkg::CH_X)
        begin
            cnt = 0;
            v = 0;
            while (cnt < 2)
            begin
                c = fetch(2 + cnt);
                if (esc_short)
                    return 0;
                if (c < 0 || !is_hex(c))
                    break;
                v = {v[27:0], nib(c)};
                cnt++;
            end
            if (cnt == 0)
                return reject(c1);
            esc_bytes.push_back(v[7:0]);
            return 2 + cnt;
        end
        if (c1 == sed_pkg::CH_LU)
        begin
            ok = read_hex(2, 4, cp);
            if (esc_short)
                return 0;
            if (!ok)
                return reject(c1);
            if (cp[15:0] >= sed_pkg::HI_FIRST && cp[15:0] <= sed_pkg::HI_LAST)
            begin
                pair = 0;
                lo = 0;
                c = fetch(6);
                if (esc_short)
                    return 0;
                if (c == sed_pkg::CH_BSLASH)
                begin
                    c = fetch(7);
                    if (esc_short)
                        return 0;
                    if (c == sed_pkg::CH_LU)
                    begin
                        pair = read_hex(8, 4, lo);
                        if (esc_short)
                            return 0;
                    end
                end
                if (pair && lo[15:0] >= sed_pkg::LO_FIRST && lo[15:0] <= sed_pkg::LO_LAST)
                begin
                    add_utf8(sed_pkg::CP_PLANE1 + ((cp - sed_pkg::SUR_FIRST) << 10)
                             + (lo - sed_pkg::LO_FIRST));
                    return 12;
                end
                return reject(c1);
            end
            if (!cp_valid(cp))
                return reject(c1);
            add_utf8(cp);
            return 6;
        end
        if (c1 == sed_pkg::CH_UU)
        begin
            ok = read_hex(2, 8, cp);
            if (esc_short)
                return 0;
            if (!ok || !cp_valid(cp))
                return reject(c1);
            add_utf8(cp);
            return 10;
        end
        if (c1 >= sed_pkg::CH_0 && c1 <= sed_pkg::CH_7)
        begin
            cnt = 1;
            v = c1 - sed_pkg::CH_0;
            while (cnt < 3)
            begin
                c = fetch(1 + cnt);
                if (esc_short)
                    return 0;
                if (c < sed_pkg::CH_0 || c > sed_pkg::CH_7)
                    break;
                v = (v << 3) | (c - sed_pkg::CH_0);
                cnt++;
            end
            esc_bytes.push_back(v[7:0]);
            return 1 + cnt;
        end
        return reject(c1);
    endfunction

    // Take one source word and queue the bytes it releases.
    function automatic void decode_word(logic [7:0] ch, logic last);
        logic [7:0] out_q[$];
        int         start;
        int         used;
        byte_exp_t  e;
        if (held_count < HOLD_DEPTH)
        begin
            held_chars[held_count] = ch;
            held_count++;
        end
        start = 0;
        while (start < held_count)
        begin
            if (held_chars[start] != sed_pkg::CH_BSLASH)
            begin
                esc_bytes = {held_chars[start]};
                used = 1;
            end
            else
            begin
                esc_start = start;
                esc_len   = held_count - start;
                esc_final = last;
                used = decide_escape();
                if (used == 0)
                    break;
            end
            foreach (esc_bytes[i])
                if (out_q.size() < MAX_BYTES)
                    out_q.push_back(esc_bytes[i]);
            start += used;
        end
        if (start > held_count)
            start = held_count;
        for (int i = 0; i + start < held_count; i++)
            held_chars[i] = held_chars[i + start];
        held_count -= start;
        if (last)
            held_count = 0;
        foreach (out_q[k])
        begin
            e.value    = out_q[k];
            e.run_last = (k == out_q.size() - 1);
            e.text_end = e.run_last && last;
            expected_bytes.push_back(e);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        byte_exp_t e;
        if (!rst_n)
        begin
            held_count = 0;
            failures   = 0;
            expected_bytes.delete();
            outstanding = 0;
        end
        else
        begin
            if (text.valid && text.ready)
                decode_word(text.in_char, text.text_last);
            if (decoded.valid && decoded.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected byte %h run_last %b text_end %b",
                                 decoded.out_byte, decoded.run_last, decoded.text_end);
                end
                else
                begin
                    e = expected_bytes.pop_front();
                    if (e.value !== decoded.out_byte || e.run_last !== decoded.run_last ||
                        e.text_end !== decoded.text_end)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("byte mismatch: expected %h/%b/%b got %h/%b/%b",
                                     e.value, e.run_last, e.text_end, decoded.out_byte,
                                     decoded.run_last, decoded.text_end);
                    end
                end
            end
            outstanding = expected_bytes.size();
        end
    end

endmodule

FILE: verif/string_escape_decoder_test.sv
// Testbench top for the string escape decoder: stimulus, idling and verdict.
`timescale 1ns / 100ps

module string_escape_decoder_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 230;

    logic clk;
    logic rst_n;
    int   failures;
    int   outstanding;
    int   cycles;
    int   words_sent;
    int   quiet_left;
    bit   drained;
    bit   send_idle;  // sender may insert gaps
    bit   recv_idle;  // receiver may stall

    logic [7:0] text_q[$];

    sed_text_if text();
    sed_byte_if decoded();

    string_escape_decoder dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .decoded (decoded)
    );

    sed_byte_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text),
        .decoded     (decoded),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stalls with a probability of about 15 percent while stalling is enabled.
    always @(posedge clk)
        decoded.ready <= recv_idle ? ($urandom_range(99) >= 15) : 1'b1;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive one word and hold it until accepted; valid stays high for a
    // back-to-back word so it never drops and rises in the same step.
    task automatic send_char(logic [7:0] c, logic last);
        while (send_idle && $urandom_range(99) < 15)
        begin
            text.valid <= 1'b0;
            @(posedge clk);
        end
        text.valid     <= 1'b1;
        text.in_char   <= c;
        text.text_last <= last;
        @(posedge clk);
        while (!text.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Send the assembled text, marking its final character.
    task automatic send_text();
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 10)
            return sed_pkg::CH_0 + v;
        return 8'(($urandom_range(1) ? sed_pkg::CH_LA : sed_pkg::CH_UA) + v - 10);
    endfunction

    task automatic add_hex(logic [31:0] v, int digits);
        for (int i = digits - 1; i >= 0; i--)
            text_q.push_back(hex_char(v[i*4 +: 4]));
    endtask

    task automatic add_escape(logic [7:0] letter);
        text_q.push_back(sed_pkg::CH_BSLASH);
        text_q.push_back(letter);
    endtask

    // Append one random fragment: mostly well-formed escapes, some noise.
    task automatic add_fragment();
        logic [7:0] simple_set[10];
        logic [31:0] hi;
        simple_set = '{sed_pkg::CH_N, sed_pkg::CH_T, sed_pkg::CH_R, sed_pkg::CH_A,
                       sed_pkg::CH_B, sed_pkg::CH_F, sed_pkg::CH_V, sed_pkg::CH_BSLASH,
                       sed_pkg::CH_SQUOTE, sed_pkg::CH_DQUOTE};
        case ($urandom_range(11))
            0, 1: text_q.push_back(8'($urandom_range(255)));
            2: add_escape(simple_set[$urandom_range(9)]);
            3:
            begin
                add_escape(sed_pkg::CH_X);
                add_hex($urandom_range(255), $urandom_range(1, 2));
            end
            4:
            begin
                text_q.push_back(sed_pkg::CH_BSLASH);
                repeat ($urandom_range(1, 3))
                    text_q.push_back(8'(sed_pkg::CH_0 + $urandom_range(7)));
            end
            5:
            begin
                add_escape(sed_pkg::CH_LU);
                add_hex($urandom_range(16'hD7FF), 4);
            end
            6:
            begin
                // surrogate pair, occasionally with a bad low half
                add_escape(sed_pkg::CH_LU);
                add_hex($urandom_range(sed_pkg::HI_FIRST, sed_pkg::HI_LAST), 4);
                add_escape(sed_pkg::CH_LU);
                if ($urandom_range(3) == 0)
                    add_hex($urandom_range(16'hFFFF), 4);
                else
                    add_hex($urandom_range(sed_pkg::LO_FIRST, sed_pkg::LO_LAST), 4);
            end
            7:
            begin
                add_escape(sed_pkg::CH_UU);
                hi = $urandom_range(3) == 0 ? $urandom() : $urandom_range(sed_pkg::CP_MAX);
                add_hex(hi, 8);
            end
            8:
            begin
                // truncated hex run
                add_escape($urandom_range(1) ? sed_pkg::CH_LU : sed_pkg::CH_UU);
                add_hex($urandom(), $urandom_range(0, 3));
            end
            9: add_escape(8'($urandom_range(255)));
            10: text_q.push_back(sed_pkg::CH_BSLASH);
            default: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        endcase
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cycles         = 0;
        words_sent     = 0;
        quiet_left     = 6;
        drained        = 1'b0;
        send_idle      = 1'b0;
        recv_idle      = 1'b0;
        text.valid     = 1'b0;
        text.in_char   = 8'h00;
        text.text_last = 1'b0;
        decoded.ready  = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, each escape kind, the end-of-text cases.
        text_q = {8'h00, 8'hFF};
        send_text();
        add_str("\\n\\t\\r\\a\\b\\f\\v\\\\\\'\\\"");
        send_text();
        add_str("\\x0\\0\\u0000\\xFf\\777");
        send_text();
        add_str("\\uD83D\\uDE00\\U0010FFFF\\U00110000\\uDC00");
        send_text();
        add_str("\\q\\xg\\uD800x\\u12");
        send_text();
        add_str("\\");
        send_text();
        add_str("\\x");
        send_text();

        // Random texts; receiver stalls and sender gaps on, except for a
        // quiet run of texts in the middle.
        send_idle = 1'b1;
        recv_idle = 1'b1;
        while (words_sent < RANDOM_WORDS)
        begin
            if (words_sent >= 130 && quiet_left > 0)
            begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
                quiet_left--;
            end
            else
            begin
                send_idle = 1'b1;
                recv_idle = 1'b1;
            end
            repeat ($urandom_range(1, 6))
                add_fragment();
            send_text();
            // hold off the sender once until the decoder drains
            if (!drained && words_sent >= 100)
            begin
                drained = 1'b1;
                text.valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
        end
        text.valid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/sed_pkg.sv
design/sed_if.sv
design/sed_front.sv
design/sed_back.sv
design/string_escape_decoder.sv
design/sed_checker.sv
verif/sed_byte_checker.sv
verif/string_escape_decoder_test.sv
